FILE: rtl/xtkbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the XT keyboard host receiver.
// No dependencies; the core takes everything by scoped names.

package xtkbd_pkg;

    // Event codes carried on the op field
    typedef enum logic [2:0] {
        OP_EDGE       = 3'd0,
        OP_TICK       = 3'd1,
        OP_READ       = 3'd2,
        OP_SOFT_RESET = 3'd3,
        OP_HARD_RESET = 3'd4,
        OP_ENABLE     = 3'd5,
        OP_DISABLE    = 3'd6,
        OP_UNUSED     = 3'd7
    } op_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_START_GAP_THRESHOLD   = 3'd0,
        CFG_SINGLE_START_BIT      = 3'd1,
        CFG_SOFT_RESET_ENABLE     = 3'd2,
        CFG_RESET_LINE_ENABLE     = 3'd3,
        CFG_POWER_ON_RESET_ENABLE = 3'd4,
        CFG_SOFT_RESET_TICKS      = 3'd5,
        CFG_RESET_RELEASE_TICK    = 3'd6,
        CFG_POWER_ON_TICKS        = 3'd7
    } cfg_index_t;

    // Link sequencer state
    typedef enum logic [3:0] {
        LINK_OFF  = 4'b0001,
        LINK_POR  = 4'b0010,
        LINK_SOFT = 4'b0100,
        LINK_IDLE = 4'b1000
    } link_mode_t;

    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int TICK_W       = 16;
    localparam int GAP_W        = 8;
    localparam int CODE_W       = 8;
    localparam int PHASE_W      = 4;
    localparam int STATUS_W     = 4;

    // Status bit positions
    localparam int ST_FULL  = 0;
    localparam int ST_FERR  = 1;
    localparam int ST_KBD   = 2;
    localparam int ST_READY = 3;

    // Bit phase landmarks
    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START1     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START2     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DATA_FIRST = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DATA_LAST  = 4'd10;

    localparam logic [CODE_W-1:0] SELF_TEST_CODE = 8'hAA;

    // Configuration reset values
    localparam logic [GAP_W-1:0]  RST_START_GAP_THRESHOLD   = 8'd100;
    localparam logic              RST_SINGLE_START_BIT      = 1'b0;
    localparam logic              RST_SOFT_RESET_ENABLE     = 1'b1;
    localparam logic              RST_RESET_LINE_ENABLE     = 1'b0;
    localparam logic              RST_POWER_ON_RESET_ENABLE = 1'b1;
    localparam logic [TICK_W-1:0] RST_SOFT_RESET_TICKS      = 16'd20;
    localparam logic [TICK_W-1:0] RST_RESET_RELEASE_TICK    = 16'd500;
    localparam logic [TICK_W-1:0] RST_POWER_ON_TICKS        = 16'd1000;

endpackage

FILE: rtl/xt_keyboard_host_receiver_core.sv
`timescale 1ns / 1ps
// XT keyboard host receiver: frame decoder, status and reset-timing sequencer.
// Depends on xtkbd_pkg for event codes, register indexes and constants.
//
// Usage:
//   Input channel (s_*): one event word per handshake - a falling keyboard
//   clock edge with its data level, gap ticks and gap overflow; a timer tick;
//   a host read; soft reset; hard reset; enable; disable.
//   Result channel (m_*): exactly one word per event, showing the receive
//   buffer, the four status flags, the clock/reset line drives and whether
//   clock edges are being listened to, all as they stand after the event.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index;
//   write only while no event is in flight.
// Timing:
//   An event lands in the input register when it is accepted, is decoded in
//   one pass against the state registers and leaves from the result register,
//   which loads together with the state registers once the result channel is free.
//   One event per cycle is sustained while m_ready is high, set by the single state-update stage.
//   s_ready drops only while both registers hold a word and m_ready is low,
//   so in that case it follows m_ready combinationally.
// Reset:
//   aresetn low clears the frame decoder, status, sequencer (disabled, lines
//   released) and reloads the configuration defaults. A stalled result
//   channel holds the result register, then the input register, then s_ready.

module xt_keyboard_host_receiver_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic        s_data_line,
    input  logic [7:0]  s_gap_ticks,
    input  logic        s_gap_overflow,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_code_waiting,
    output logic        m_frame_error,
    output logic        m_keyboard_detected,
    output logic        m_ready_res,
    output logic        m_clock_hold_low,
    output logic        m_reset_hold_low,
    output logic        m_listening,

    input  logic        cfg_we,
    input  logic [xtkbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [xtkbd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // Configuration registers
    logic [xtkbd_pkg::GAP_W-1:0]  start_gap_threshold_reg;
    logic                         single_start_bit_reg;
    logic                         soft_reset_enable_reg;
    logic                         reset_line_enable_reg;
    logic                         power_on_reset_enable_reg;
    logic [xtkbd_pkg::TICK_W-1:0] soft_reset_ticks_reg;
    logic [xtkbd_pkg::TICK_W-1:0] reset_release_tick_reg;
    logic [xtkbd_pkg::TICK_W-1:0] power_on_ticks_reg;

    // Input register
    logic                         in_valid_reg;
    logic [2:0]                   in_op_reg;
    logic                         in_data_reg;
    logic [xtkbd_pkg::GAP_W-1:0]  in_gap_reg;
    logic                         in_ovf_reg;

    // Block state
    logic [xtkbd_pkg::PHASE_W-1:0]  bit_phase_reg,   bit_phase_next;
    logic [xtkbd_pkg::CODE_W-1:0]   shift_value_reg, shift_value_next;
    logic [xtkbd_pkg::CODE_W-1:0]   held_code_reg,   held_code_next;
    logic                           bad_start_reg,   bad_start_next;
    logic [xtkbd_pkg::STATUS_W-1:0] status_reg,      status_next;
    xtkbd_pkg::link_mode_t          link_mode_reg,   link_mode_next;
    logic [xtkbd_pkg::TICK_W-1:0]   tick_count_reg,  tick_count_next;
    logic                           edge_enable_reg, edge_enable_next;
    logic                           clock_drive_reg, clock_drive_next;
    logic                           reset_drive_reg, reset_drive_next;

    // Result register
    logic                           out_valid_reg;
    logic [xtkbd_pkg::CODE_W-1:0]   out_code_reg;
    logic [xtkbd_pkg::STATUS_W-1:0] out_status_reg;
    logic                           out_clock_reg;
    logic                           out_reset_reg;
    logic                           out_listen_reg;

    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_gap_threshold_reg   <= xtkbd_pkg::RST_START_GAP_THRESHOLD;
            single_start_bit_reg      <= xtkbd_pkg::RST_SINGLE_START_BIT;
            soft_reset_enable_reg     <= xtkbd_pkg::RST_SOFT_RESET_ENABLE;
            reset_line_enable_reg     <= xtkbd_pkg::RST_RESET_LINE_ENABLE;
            power_on_reset_enable_reg <= xtkbd_pkg::RST_POWER_ON_RESET_ENABLE;
            soft_reset_ticks_reg      <= xtkbd_pkg::RST_SOFT_RESET_TICKS;
            reset_release_tick_reg    <= xtkbd_pkg::RST_RESET_RELEASE_TICK;
            power_on_ticks_reg        <= xtkbd_pkg::RST_POWER_ON_TICKS;
        end else if (cfg_we) begin
            case (xtkbd_pkg::cfg_index_t'(cfg_index))
                xtkbd_pkg::CFG_START_GAP_THRESHOLD:
                    start_gap_threshold_reg <= cfg_wdata[xtkbd_pkg::GAP_W-1:0];
                xtkbd_pkg::CFG_SINGLE_START_BIT:      single_start_bit_reg <= cfg_wdata[0];
                xtkbd_pkg::CFG_SOFT_RESET_ENABLE:     soft_reset_enable_reg <= cfg_wdata[0];
                xtkbd_pkg::CFG_RESET_LINE_ENABLE:     reset_line_enable_reg <= cfg_wdata[0];
                xtkbd_pkg::CFG_POWER_ON_RESET_ENABLE: power_on_reset_enable_reg <= cfg_wdata[0];
                xtkbd_pkg::CFG_SOFT_RESET_TICKS:      soft_reset_ticks_reg <= cfg_wdata;
                xtkbd_pkg::CFG_RESET_RELEASE_TICK:    reset_release_tick_reg <= cfg_wdata;
                xtkbd_pkg::CFG_POWER_ON_TICKS:        power_on_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: load on every accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_op;
            in_data_reg <= s_data_line;
            in_gap_reg  <= s_gap_ticks;
            in_ovf_reg  <= s_gap_overflow;
        end
    end

    // Event decode and state update
    always_comb begin
        logic [xtkbd_pkg::PHASE_W-1:0] phase;
        logic [xtkbd_pkg::CODE_W-1:0]  shifted;
        logic [xtkbd_pkg::TICK_W-1:0]  tick_inc;

        bit_phase_next   = bit_phase_reg;
        shift_value_next = shift_value_reg;
        held_code_next   = held_code_reg;
        bad_start_next   = bad_start_reg;
        status_next      = status_reg;
        link_mode_next   = link_mode_reg;
        tick_count_next  = tick_count_reg;
        edge_enable_next = edge_enable_reg;
        clock_drive_next = clock_drive_reg;
        reset_drive_next = reset_drive_reg;

        phase    = bit_phase_reg;
        shifted  = {in_data_reg, shift_value_reg[xtkbd_pkg::CODE_W-1:1]};
        tick_inc = tick_count_reg + 1'b1;

        case (xtkbd_pkg::op_t'(in_op_reg))
            xtkbd_pkg::OP_EDGE: begin
                if (edge_enable_reg) begin
                    // long gap or wrapped timer: start a fresh frame
                    if ((in_gap_reg > start_gap_threshold_reg) || in_ovf_reg) begin
                        status_next[xtkbd_pkg::ST_FULL] = 1'b0;
                        status_next[xtkbd_pkg::ST_FERR] = 1'b0;
                        phase = xtkbd_pkg::PH_IDLE;
                    end
                    phase = phase + 1'b1;
                    bit_phase_next = phase;
                    if (phase == xtkbd_pkg::PH_START1) begin
                        shift_value_next = '0;
                        bad_start_next   = 1'b0;
                        if (single_start_bit_reg) begin
                            bit_phase_next = xtkbd_pkg::PH_START2;
                            bad_start_next = !in_data_reg;
                        end
                    end else if (phase == xtkbd_pkg::PH_START2) begin
                        if (!in_data_reg) begin
                            bad_start_next = 1'b1;
                        end
                    end else if (phase >= xtkbd_pkg::PH_DATA_FIRST &&
                                 phase <= xtkbd_pkg::PH_DATA_LAST) begin
                        shift_value_next = shifted;
                        if (phase == xtkbd_pkg::PH_DATA_LAST) begin
                            clock_drive_next = 1'b1;
                            if (bad_start_reg) begin
                                status_next[xtkbd_pkg::ST_FERR] = 1'b1;
                            end else if (shifted == xtkbd_pkg::SELF_TEST_CODE &&
                                         !status_reg[xtkbd_pkg::ST_KBD]) begin
                                status_next[xtkbd_pkg::ST_KBD] = 1'b1;
                                clock_drive_next = 1'b0;
                            end else begin
                                held_code_next = shifted;
                                status_next[xtkbd_pkg::ST_FULL] = 1'b1;
                            end
                            bit_phase_next = xtkbd_pkg::PH_IDLE;
                        end
                    end
                end
            end
            xtkbd_pkg::OP_TICK: begin
                tick_count_next = tick_inc;
                if (link_mode_reg == xtkbd_pkg::LINK_SOFT) begin
                    if (tick_inc >= soft_reset_ticks_reg) begin
                        clock_drive_next = 1'b0;
                        edge_enable_next = 1'b1;
                        tick_count_next  = '0;
                        link_mode_next   = xtkbd_pkg::LINK_IDLE;
                        status_next[xtkbd_pkg::ST_READY] = 1'b1;
                    end
                end else if (link_mode_reg == xtkbd_pkg::LINK_POR) begin
                    if (tick_inc == reset_release_tick_reg) begin
                        if (reset_line_enable_reg) begin
                            reset_drive_next = 1'b0;
                        end
                    end else if (tick_inc >= power_on_ticks_reg) begin
                        if (soft_reset_enable_reg) begin
                            clock_drive_next = 1'b1;
                            tick_count_next  = '0;
                        end else begin
                            tick_count_next  = soft_reset_ticks_reg;
                        end
                        link_mode_next = xtkbd_pkg::LINK_SOFT;
                    end
                end
            end
            xtkbd_pkg::OP_READ: begin
                if (status_reg[xtkbd_pkg::ST_FULL]) begin
                    status_next[xtkbd_pkg::ST_FULL] = 1'b0;
                    status_next[xtkbd_pkg::ST_FERR] = 1'b0;
                    status_next[xtkbd_pkg::ST_KBD]  = 1'b1;
                    clock_drive_next = 1'b0;
                end
            end
            xtkbd_pkg::OP_SOFT_RESET: begin
                if (soft_reset_enable_reg) begin
                    edge_enable_next = 1'b0;
                    status_next      = '0;
                    link_mode_next   = xtkbd_pkg::LINK_SOFT;
                    clock_drive_next = 1'b1;
                    tick_count_next  = '0;
                end
            end
            xtkbd_pkg::OP_HARD_RESET: begin
                edge_enable_next = 1'b0;
                clock_drive_next = 1'b0;
                link_mode_next   = xtkbd_pkg::LINK_POR;
                tick_count_next  = '0;
                if (reset_line_enable_reg) begin
                    reset_drive_next = 1'b1;
                end
            end
            xtkbd_pkg::OP_ENABLE: begin
                bit_phase_next  = xtkbd_pkg::PH_IDLE;
                status_next     = '0;
                tick_count_next = '0;
                if (power_on_reset_enable_reg) begin
                    edge_enable_next = 1'b0;
                    clock_drive_next = 1'b0;
                    link_mode_next   = xtkbd_pkg::LINK_POR;
                    if (reset_line_enable_reg) begin
                        reset_drive_next = 1'b1;
                    end
                end else begin
                    edge_enable_next = 1'b1;
                    link_mode_next   = xtkbd_pkg::LINK_IDLE;
                end
            end
            xtkbd_pkg::OP_DISABLE: begin
                edge_enable_next = 1'b0;
                link_mode_next   = xtkbd_pkg::LINK_OFF;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_phase_reg   <= xtkbd_pkg::PH_IDLE;
            shift_value_reg <= '0;
            held_code_reg   <= '0;
            bad_start_reg   <= 1'b0;
            status_reg      <= '0;
            link_mode_reg   <= xtkbd_pkg::LINK_OFF;
            tick_count_reg  <= '0;
            edge_enable_reg <= 1'b0;
            clock_drive_reg <= 1'b0;
            reset_drive_reg <= 1'b0;
        end else if (advance) begin
            bit_phase_reg   <= bit_phase_next;
            shift_value_reg <= shift_value_next;
            held_code_reg   <= held_code_next;
            bad_start_reg   <= bad_start_next;
            status_reg      <= status_next;
            link_mode_reg   <= link_mode_next;
            tick_count_reg  <= tick_count_next;
            edge_enable_reg <= edge_enable_next;
            clock_drive_reg <= clock_drive_next;
            reset_drive_reg <= reset_drive_next;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_code_reg   <= held_code_next;
            out_status_reg <= status_next;
            out_clock_reg  <= clock_drive_next;
            out_reset_reg  <= reset_drive_next;
            out_listen_reg <= edge_enable_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_read_data         = out_code_reg;
    assign m_code_waiting      = out_status_reg[xtkbd_pkg::ST_FULL];
    assign m_frame_error       = out_status_reg[xtkbd_pkg::ST_FERR];
    assign m_keyboard_detected = out_status_reg[xtkbd_pkg::ST_KBD];
    assign m_ready_res         = out_status_reg[xtkbd_pkg::ST_READY];
    assign m_clock_hold_low    = out_clock_reg;
    assign m_reset_hold_low    = out_reset_reg;
    assign m_listening         = out_listen_reg;

`ifndef NO_ASSERTIONS
    // sequencer state stays one-hot
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(link_mode_reg))
        else $error("link mode not one-hot");

    // edges are only taken once the sequencer has reached idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        edge_enable_reg |-> (link_mode_reg == xtkbd_pkg::LINK_IDLE))
        else $error("listening outside idle link mode");

    // a frame never rests past the last data bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        bit_phase_reg < xtkbd_pkg::PH_DATA_LAST)
        else $error("bit phase out of range");

    // a word waiting behind a stalled result must be held, not processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=>
            (in_valid_reg && $stable(in_op_reg) && $stable(status_reg)))
        else $error("stalled word was lost or state moved");
`endif

endmodule
